>>> rtl/vsdm_pkg.sv
// Shared types and constants for the vehicle safety decision monitor.
`timescale 1ns / 1ps
package vsdm_pkg;

  typedef enum logic [2:0] {
    CMD_HEALTH = 3'd0,
    CMD_LIST   = 3'd1,
    CMD_OBJECT = 3'd2,
    CMD_SPEED  = 3'd3,
    CMD_KICK   = 3'd4,
    CMD_EVAL   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    DEC_NOMINAL = 3'd0,
    DEC_WARN    = 3'd1,
    DEC_DEGRADE = 3'd2,
    DEC_MRC     = 3'd3,
    DEC_STOP    = 3'd4
  } decision_t;

  typedef enum logic [2:0] {
    REG_BRAKE  = 3'd0,
    REG_WARN   = 3'd1,
    REG_MARGIN = 3'd2,
    REG_FUSION = 3'd3,
    REG_PLAN   = 3'd4,
    REG_CTRL   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    WD_FUSION = 2'd0,
    WD_PLAN   = 2'd1,
    WD_CTRL   = 2'd2,
    WD_NONE   = 2'd3
  } wd_t;

  localparam logic [15:0] TTC_START    = 16'd9900;
  localparam logic [15:0] BRAKE_RESET  = 16'd150;
  localparam logic [15:0] WARN_RESET   = 16'd300;
  localparam logic [14:0] MARGIN_RESET = 15'd200;
  localparam logic [15:0] FUSION_RESET = 16'd100;
  localparam logic [15:0] PLAN_RESET   = 16'd200;
  localparam logic [15:0] CTRL_RESET   = 16'd50;

  // one classified event waiting for the back end
  typedef struct packed {
    cmd_t        op;
    logic [2:0]  fail;
    logic [15:0] ttc;
    logic        ovs;
    wd_t         pick;
    logic [31:0] time_ms;
  } entry_t;

endpackage

>>> rtl/vsdm_front.sv
// Front end: decodes events, drops no-op ones, precomputes the overspeed test.
`timescale 1ns / 1ps
module vsdm_front (
  input  logic [2:0]       command,
  input  logic             lidar_bad,
  input  logic             camera_bad,
  input  logic             radar_bad,
  input  logic [15:0]      ttc_centis,
  input  logic signed [15:0] ego_speed,
  input  logic signed [15:0] cmd_speed,
  input  logic [1:0]       watchdog_pick,
  input  logic [31:0]      time_ms,
  input  logic [14:0]      speed_margin,
  output logic             keep,
  output vsdm_pkg::entry_t entry
);

  logic signed [17:0] ego_w;
  logic signed [17:0] lim_w;

  assign ego_w = {{2{ego_speed[15]}}, ego_speed};
  assign lim_w = {{2{cmd_speed[15]}}, cmd_speed} + $signed({3'b000, speed_margin});

  always_comb begin
    entry.op      = vsdm_pkg::CMD_HEALTH;
    entry.fail    = {radar_bad, camera_bad, lidar_bad};
    entry.ttc     = ttc_centis;
    entry.ovs     = ego_w > lim_w;
    entry.pick    = vsdm_pkg::wd_t'(watchdog_pick);
    entry.time_ms = time_ms;
    keep          = 1'b1;
    unique case (command)
      vsdm_pkg::CMD_HEALTH: entry.op = vsdm_pkg::CMD_HEALTH;
      vsdm_pkg::CMD_LIST:   entry.op = vsdm_pkg::CMD_LIST;
      vsdm_pkg::CMD_OBJECT: entry.op = vsdm_pkg::CMD_OBJECT;
      vsdm_pkg::CMD_SPEED:  entry.op = vsdm_pkg::CMD_SPEED;
      vsdm_pkg::CMD_KICK: begin
        entry.op = vsdm_pkg::CMD_KICK;
        keep     = watchdog_pick != vsdm_pkg::WD_NONE;
      end
      vsdm_pkg::CMD_EVAL:   entry.op = vsdm_pkg::CMD_EVAL;
      default:              keep = 1'b0;
    endcase
  end

endmodule

>>> rtl/vsdm_queue.sv
// Small FIFO of classified events between front and back ends.
`timescale 1ns / 1ps
module vsdm_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vsdm_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output vsdm_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  vsdm_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == FULL_COUNT;
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/vsdm_back.sv
// Back end: settings, monitor state, watchdog checks and the result register.
`timescale 1ns / 1ps
module vsdm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic [14:0]      speed_margin,
  input  logic             q_valid,
  input  vsdm_pkg::entry_t q_head,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [2:0]       decision,
  output logic             fusion_late,
  output logic             plan_late,
  output logic             ctrl_late,
  output logic [15:0]      nearest_ttc
);

  logic [15:0] brake_limit;
  logic [15:0] warn_limit;
  logic [15:0] fusion_limit;
  logic [15:0] plan_limit;
  logic [15:0] ctrl_limit;

  logic [15:0] min_ttc;
  logic        brake_needed;
  logic        overspeed;
  logic [2:0]  fail_bits;
  logic [31:0] kick [3];

  logic [15:0] min_ttc_next;
  logic        f_late;
  logic        p_late;
  logic        c_late;
  logic [1:0]  fails;
  vsdm_pkg::decision_t dec_next;
  logic        slot_free;

  assign slot_free = !result_valid || result_ready;
  assign q_pop = q_valid && (q_head.op != vsdm_pkg::CMD_EVAL || slot_free);

  always_comb begin
    min_ttc_next = min_ttc;
    if (q_head.op == vsdm_pkg::CMD_LIST) begin
      min_ttc_next = vsdm_pkg::TTC_START;
    end else if (q_head.ttc != '0 && q_head.ttc < min_ttc) begin
      min_ttc_next = q_head.ttc;
    end
  end

  assign f_late = (q_head.time_ms - kick[0]) > {16'h0000, fusion_limit};
  assign p_late = (q_head.time_ms - kick[1]) > {16'h0000, plan_limit};
  assign c_late = (q_head.time_ms - kick[2]) > {16'h0000, ctrl_limit};
  assign fails  = {1'b0, fail_bits[0]} + {1'b0, fail_bits[1]} + {1'b0, fail_bits[2]};

  always_comb begin
    if (brake_needed || overspeed || c_late) begin
      dec_next = vsdm_pkg::DEC_STOP;
    end else if (fails >= 2'd2 || p_late) begin
      dec_next = vsdm_pkg::DEC_MRC;
    end else if (fails == 2'd1 || f_late) begin
      dec_next = vsdm_pkg::DEC_DEGRADE;
    end else if (min_ttc < warn_limit) begin
      dec_next = vsdm_pkg::DEC_WARN;
    end else begin
      dec_next = vsdm_pkg::DEC_NOMINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_limit  <= vsdm_pkg::BRAKE_RESET;
      warn_limit   <= vsdm_pkg::WARN_RESET;
      speed_margin <= vsdm_pkg::MARGIN_RESET;
      fusion_limit <= vsdm_pkg::FUSION_RESET;
      plan_limit   <= vsdm_pkg::PLAN_RESET;
      ctrl_limit   <= vsdm_pkg::CTRL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vsdm_pkg::REG_BRAKE:  brake_limit  <= cfg_data;
        vsdm_pkg::REG_WARN:   warn_limit   <= cfg_data;
        vsdm_pkg::REG_MARGIN: speed_margin <= cfg_data[14:0];
        vsdm_pkg::REG_FUSION: fusion_limit <= cfg_data;
        vsdm_pkg::REG_PLAN:   plan_limit   <= cfg_data;
        vsdm_pkg::REG_CTRL:   ctrl_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_ttc      <= vsdm_pkg::TTC_START;
      brake_needed <= 1'b0;
      overspeed    <= 1'b0;
      fail_bits    <= '0;
      kick[0]      <= '0;
      kick[1]      <= '0;
      kick[2]      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop && q_head.op == vsdm_pkg::CMD_EVAL) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_head.op)
          vsdm_pkg::CMD_HEALTH: fail_bits <= q_head.fail;
          vsdm_pkg::CMD_LIST, vsdm_pkg::CMD_OBJECT: begin
            min_ttc      <= min_ttc_next;
            brake_needed <= min_ttc_next < brake_limit;
          end
          vsdm_pkg::CMD_SPEED: overspeed <= q_head.ovs;
          vsdm_pkg::CMD_KICK: begin
            unique case (q_head.pick)
              vsdm_pkg::WD_FUSION: kick[0] <= q_head.time_ms;
              vsdm_pkg::WD_PLAN:   kick[1] <= q_head.time_ms;
              vsdm_pkg::WD_CTRL:   kick[2] <= q_head.time_ms;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == vsdm_pkg::CMD_EVAL) begin
      decision    <= dec_next;
      fusion_late <= f_late;
      plan_late   <= p_late;
      ctrl_late   <= c_late;
      nearest_ttc <= min_ttc;
    end
  end

endmodule

>>> rtl/vehicle_safety_decision_monitor_core.sv
// Top level of the vehicle safety decision monitor.
//
// channel  direction  handshake                  payload
// item     in         item_valid / item_ready    command .. time_ms
// result   out        result_valid / result_ready decision .. nearest_ttc
// config   in         cfg_write                  cfg_index, cfg_data
//
// One beat per cycle while the queue has room; an evaluate result passes
// through a queue write, then the back-end result register.
// The queue holds QUEUE_DEPTH beats; item_ready drops only when it is full.
// Only evaluate beats wait on a held result; other beats drain past it.
// Synchronous reset restores all limits and monitor state.
`timescale 1ns / 1ps
module vehicle_safety_decision_monitor_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [2:0]         command,
  input  logic               lidar_bad,
  input  logic               camera_bad,
  input  logic               radar_bad,
  input  logic [15:0]        ttc_centis,
  input  logic signed [15:0] ego_speed,
  input  logic signed [15:0] cmd_speed,
  input  logic [1:0]         watchdog_pick,
  input  logic [31:0]        time_ms,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [2:0]         decision,
  output logic               fusion_late,
  output logic               plan_late,
  output logic               ctrl_late,
  output logic [15:0]        nearest_ttc,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic             keep;
  vsdm_pkg::entry_t entry;
  vsdm_pkg::entry_t q_head;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [14:0]      speed_margin;

  assign item_ready = !q_full;

  vsdm_front u_front (
    .command       (command),
    .lidar_bad     (lidar_bad),
    .camera_bad    (camera_bad),
    .radar_bad     (radar_bad),
    .ttc_centis    (ttc_centis),
    .ego_speed     (ego_speed),
    .cmd_speed     (cmd_speed),
    .watchdog_pick (watchdog_pick),
    .time_ms       (time_ms),
    .speed_margin  (speed_margin),
    .keep          (keep),
    .entry         (entry)
  );

  vsdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && item_ready && keep),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  vsdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .speed_margin (speed_margin),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .decision     (decision),
    .fusion_late  (fusion_late),
    .plan_late    (plan_late),
    .ctrl_late    (ctrl_late),
    .nearest_ttc  (nearest_ttc)
  );

endmodule

>>> dv/vsdm_decision_checker.sv
// Checker for the safety monitor: tracks monitor state, predicts each decision, compares.
`timescale 1ns / 1ps
module vsdm_decision_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic [2:0]         command,
  input  logic               lidar_bad,
  input  logic               camera_bad,
  input  logic               radar_bad,
  input  logic [15:0]        ttc_centis,
  input  logic signed [15:0] ego_speed,
  input  logic signed [15:0] cmd_speed,
  input  logic [1:0]         watchdog_pick,
  input  logic [31:0]        time_ms,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic [2:0]         decision,
  input  logic               fusion_late,
  input  logic               plan_late,
  input  logic               ctrl_late,
  input  logic [15:0]        nearest_ttc,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatch_count,
  output int                 verdicts_pending
);

  typedef struct packed {
    vsdm_pkg::decision_t verdict;
    logic        fusion_late;
    logic        plan_late;
    logic        ctrl_late;
    logic [15:0] nearest;
  } verdict_t;

  logic [15:0] lim_brake, lim_warn, lim_fusion, lim_plan, lim_ctrl;
  logic [14:0] lim_margin;

  logic [15:0] ttc_floor;
  logic        brake_flag;
  logic        overspeed_flag;
  logic [2:0]  sensor_down;
  logic [31:0] kick_stamp [3];

  verdict_t verdicts_due [$];

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic absorb_event(input logic [2:0] cmd, input logic [2:0] bad,
                              input logic [15:0] ttc, input logic signed [15:0] ego,
                              input logic signed [15:0] demand, input logic [1:0] pick,
                              input logic [31:0] now);
    verdict_t    v;
    logic [31:0] elapsed_f, elapsed_p, elapsed_c;
    int          down;
    case (cmd)
      vsdm_pkg::CMD_HEALTH: sensor_down = bad;
      vsdm_pkg::CMD_LIST: begin
        ttc_floor = vsdm_pkg::TTC_START;
        brake_flag = ttc_floor < lim_brake;
      end
      vsdm_pkg::CMD_OBJECT: begin
        if (ttc != 16'd0 && ttc < ttc_floor) ttc_floor = ttc;
        brake_flag = ttc_floor < lim_brake;
      end
      vsdm_pkg::CMD_SPEED:
        overspeed_flag = int'(ego) > int'(demand) + int'(lim_margin);
      vsdm_pkg::CMD_KICK: begin
        if (pick != vsdm_pkg::WD_NONE) kick_stamp[pick] = now;
      end
      vsdm_pkg::CMD_EVAL: begin
        elapsed_f = now - kick_stamp[vsdm_pkg::WD_FUSION];
        elapsed_p = now - kick_stamp[vsdm_pkg::WD_PLAN];
        elapsed_c = now - kick_stamp[vsdm_pkg::WD_CTRL];
        v.fusion_late = elapsed_f > {16'd0, lim_fusion};
        v.plan_late = elapsed_p > {16'd0, lim_plan};
        v.ctrl_late = elapsed_c > {16'd0, lim_ctrl};
        v.nearest = ttc_floor;
        down = $countones(sensor_down);
        if (brake_flag || overspeed_flag || v.ctrl_late) v.verdict = vsdm_pkg::DEC_STOP;
        else if (down >= 2 || v.plan_late) v.verdict = vsdm_pkg::DEC_MRC;
        else if (down == 1 || v.fusion_late) v.verdict = vsdm_pkg::DEC_DEGRADE;
        else if (ttc_floor < lim_warn) v.verdict = vsdm_pkg::DEC_WARN;
        else v.verdict = vsdm_pkg::DEC_NOMINAL;
        verdicts_due.push_back(v);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      lim_brake = vsdm_pkg::BRAKE_RESET;
      lim_warn = vsdm_pkg::WARN_RESET;
      lim_margin = vsdm_pkg::MARGIN_RESET;
      lim_fusion = vsdm_pkg::FUSION_RESET;
      lim_plan = vsdm_pkg::PLAN_RESET;
      lim_ctrl = vsdm_pkg::CTRL_RESET;
      ttc_floor = vsdm_pkg::TTC_START;
      brake_flag = 1'b0;
      overspeed_flag = 1'b0;
      sensor_down = 3'b000;
      foreach (kick_stamp[i]) kick_stamp[i] = 32'd0;
      verdicts_due.delete();
      mismatch_count = 0;
      verdicts_pending <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: decision beat with nothing expected, actual decision %0d ttc %0d",
                   $time, decision, nearest_ttc);
          mismatch_count++;
        end else begin
          v = verdicts_due.pop_front();
          compare_field("decision", int'(v.verdict), int'(decision));
          compare_field("fusion_late", int'(v.fusion_late), int'(fusion_late));
          compare_field("plan_late", int'(v.plan_late), int'(plan_late));
          compare_field("ctrl_late", int'(v.ctrl_late), int'(ctrl_late));
          compare_field("nearest_ttc", int'(v.nearest), int'(nearest_ttc));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          vsdm_pkg::REG_BRAKE:  lim_brake = cfg_data;
          vsdm_pkg::REG_WARN:   lim_warn = cfg_data;
          vsdm_pkg::REG_MARGIN: lim_margin = cfg_data[14:0];
          vsdm_pkg::REG_FUSION: lim_fusion = cfg_data;
          vsdm_pkg::REG_PLAN:   lim_plan = cfg_data;
          vsdm_pkg::REG_CTRL:   lim_ctrl = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        absorb_event(command, {radar_bad, camera_bad, lidar_bad}, ttc_centis, ego_speed,
                     cmd_speed, watchdog_pick, time_ms);
      verdicts_pending <= verdicts_due.size();
    end
  end

endmodule

>>> dv/vehicle_safety_decision_monitor_core_tb.sv
// Testbench top for the safety monitor: clock, reset, event stimulus, limit setup and verdict.
`timescale 1ns / 1ps
module vehicle_safety_decision_monitor_core_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic               clk;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [2:0]         command = vsdm_pkg::CMD_HEALTH;
  logic               lidar_bad = 1'b0;
  logic               camera_bad = 1'b0;
  logic               radar_bad = 1'b0;
  logic [15:0]        ttc_centis = 16'd0;
  logic signed [15:0] ego_speed = 16'sd0;
  logic signed [15:0] cmd_speed = 16'sd0;
  logic [1:0]         watchdog_pick = vsdm_pkg::WD_FUSION;
  logic [31:0]        time_ms = 32'd0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [2:0]         decision;
  logic               fusion_late;
  logic               plan_late;
  logic               ctrl_late;
  logic [15:0]        nearest_ttc;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = vsdm_pkg::REG_BRAKE;
  logic [15:0]        cfg_data = 16'd0;

  int          mismatch_count;
  int          verdicts_pending;
  int          cycle_count;
  int          burst_left;
  int          stall_tick;
  int          stall_mode;
  int          cur_margin;
  logic [31:0] clock_ms;

  vehicle_safety_decision_monitor_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .command(command), .lidar_bad(lidar_bad), .camera_bad(camera_bad),
    .radar_bad(radar_bad), .ttc_centis(ttc_centis), .ego_speed(ego_speed),
    .cmd_speed(cmd_speed), .watchdog_pick(watchdog_pick), .time_ms(time_ms),
    .result_valid(result_valid), .result_ready(result_ready),
    .decision(decision), .fusion_late(fusion_late), .plan_late(plan_late),
    .ctrl_late(ctrl_late), .nearest_ttc(nearest_ttc),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vsdm_decision_checker decision_chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .command(command), .lidar_bad(lidar_bad), .camera_bad(camera_bad),
    .radar_bad(radar_bad), .ttc_centis(ttc_centis), .ego_speed(ego_speed),
    .cmd_speed(cmd_speed), .watchdog_pick(watchdog_pick), .time_ms(time_ms),
    .result_valid(result_valid), .result_ready(result_ready),
    .decision(decision), .fusion_late(fusion_late), .plan_late(plan_late),
    .ctrl_late(ctrl_late), .nearest_ttc(nearest_ttc),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .verdicts_pending(verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result side backpressure, in a stall mode redrawn at random
  always @(posedge clk) begin
    if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= 1'($urandom_range(0, 1));
      2: result_ready <= (stall_tick % 4 == 0);
      default: result_ready <= (stall_tick % 32 >= 24);
    endcase
    stall_tick++;
  end

  task automatic send_event(input logic [2:0] cmd, input logic [2:0] bad,
                            input logic [15:0] ttc, input logic [15:0] ego,
                            input logic [15:0] demand, input logic [1:0] pick,
                            input logic [31:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    item_valid <= 1'b1;
    command <= cmd;
    lidar_bad <= bad[0];
    camera_bad <= bad[1];
    radar_bad <= bad[2];
    ttc_centis <= ttc;
    ego_speed <= ego;
    cmd_speed <= demand;
    watchdog_pick <= pick;
    time_ms <= stamp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic random_event();
    logic [2:0]  cmd;
    logic [2:0]  bad;
    logic [15:0] ttc, ego, demand;
    logic [1:0]  pick;
    logic [31:0] stamp;
    int          roll, base, ego_i;
    bad = 3'($urandom);
    ttc = 16'($urandom);
    ego = 16'($urandom);
    demand = 16'($urandom);
    pick = 2'($urandom);
    stamp = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      cmd = vsdm_pkg::CMD_HEALTH;
      if ($urandom_range(0, 2) != 0) begin
        bad = 3'b000;
        if ($urandom_range(0, 3) == 0) bad[$urandom_range(0, 2)] = 1'b1;
      end
    end else if (roll < 16) begin
      cmd = vsdm_pkg::CMD_LIST;
    end else if (roll < 46) begin
      cmd = vsdm_pkg::CMD_OBJECT;
      roll = $urandom_range(0, 9);
      if (roll == 0) ttc = 16'd0;
      else if (roll < 7) ttc = 16'($urandom_range(1, 800));
    end else if (roll < 58) begin
      cmd = vsdm_pkg::CMD_SPEED;
      if ($urandom_range(0, 2) != 0) begin
        base = int'($urandom_range(0, 4000)) - 2000;
        ego_i = base + cur_margin + int'($urandom_range(0, 6)) - 3;
        if (ego_i > 32767) ego_i = 32767;
        if (ego_i < -32768) ego_i = -32768;
        demand = base[15:0];
        ego = ego_i[15:0];
      end
    end else if (roll < 78) begin
      cmd = vsdm_pkg::CMD_KICK;
      clock_ms += $urandom_range(0, 20);
      stamp = clock_ms - $urandom_range(0, 60);
    end else if (roll < 97) begin
      cmd = vsdm_pkg::CMD_EVAL;
      clock_ms += $urandom_range(0, 150);
      if ($urandom_range(0, 19) != 0) stamp = clock_ms;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    end
    send_event(cmd, bad, ttc, ego, demand, pick, stamp);
  endtask

  task automatic write_reg(input vsdm_pkg::reg_index_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_limits(input logic [15:0] brake, input logic [15:0] warn,
                                input logic [14:0] margin, input logic [15:0] fusion,
                                input logic [15:0] plan, input logic [15:0] ctrl);
    write_reg(vsdm_pkg::REG_BRAKE, brake);
    write_reg(vsdm_pkg::REG_WARN, warn);
    write_reg(vsdm_pkg::REG_MARGIN, {1'b0, margin});
    write_reg(vsdm_pkg::REG_FUSION, fusion);
    write_reg(vsdm_pkg::REG_PLAN, plan);
    write_reg(vsdm_pkg::REG_CTRL, ctrl);
    cfg_write <= 1'b0;
    cur_margin = int'(margin);
    clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_C000;
  endtask

  // stop sending and let every decision come out, plus queue drain time
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    burst_left = 0;
    stall_tick = 0;
    stall_mode = 0;
    cur_margin = int'(vsdm_pkg::MARGIN_RESET);
    clock_ms = 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset limits
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd10);
    send_event(vsdm_pkg::CMD_HEALTH, 3'b111, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd10);
    send_event(vsdm_pkg::CMD_HEALTH, 3'b001, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd10);
    send_event(vsdm_pkg::CMD_HEALTH, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_LIST, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_OBJECT, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_OBJECT, 3'b000, 16'hFFFF, 16'd0, 16'd0, vsdm_pkg::WD_FUSION,
               32'd0);
    send_event(vsdm_pkg::CMD_OBJECT, 3'b000, 16'd200, 16'd0, 16'd0, vsdm_pkg::WD_FUSION,
               32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd10);
    send_event(vsdm_pkg::CMD_OBJECT, 3'b000, 16'd1, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd10);
    send_event(vsdm_pkg::CMD_LIST, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_SPEED, 3'b000, 16'd0, 16'h7FFF, 16'h8000, vsdm_pkg::WD_FUSION,
               32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd10);
    send_event(vsdm_pkg::CMD_SPEED, 3'b000, 16'd0, 16'd400, 16'd200, vsdm_pkg::WD_FUSION,
               32'd0);
    send_event(vsdm_pkg::CMD_SPEED, 3'b000, 16'd0, 16'h8000, 16'h7FFF, vsdm_pkg::WD_FUSION,
               32'd0);
    send_event(vsdm_pkg::CMD_KICK, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION,
               32'hFFFF_FFF0);
    send_event(vsdm_pkg::CMD_KICK, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_PLAN,
               32'hFFFF_FFF0);
    send_event(vsdm_pkg::CMD_KICK, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_CTRL,
               32'hFFFF_FFF0);
    send_event(vsdm_pkg::CMD_KICK, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_NONE, 32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION,
               32'h0000_0010);
    send_event(CMD_SPARE_A, 3'b111, 16'd5, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(CMD_SPARE_B, 3'b111, 16'd5, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION,
               32'h8000_0000);

    // limits at their top: empty list already brakes
    drain_results();
    program_limits(16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(vsdm_pkg::CMD_LIST, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION, 32'd0);
    send_event(vsdm_pkg::CMD_EVAL, 3'b000, 16'd0, 16'd0, 16'd0, vsdm_pkg::WD_FUSION,
               clock_ms);
    repeat (150) random_event();

    drain_results();
    program_limits(16'd0, 16'd0, 15'd0, 16'd0, 16'd0, 16'd0);
    repeat (150) random_event();

    repeat (5) begin
      drain_results();
      program_limits(16'($urandom_range(0, 400)), 16'($urandom_range(100, 1200)),
                     15'($urandom_range(0, 1000)), 16'($urandom_range(20, 300)),
                     16'($urandom_range(20, 300)), 16'($urandom_range(20, 300)));
      repeat (200) random_event();
    end

    drain_results();
    if (mismatch_count == 0 && verdicts_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
